@@ rtl/b64_pkg.sv @@
// shared types, constants and the symbol mapping for the base64 stream encoder
`default_nettype none

package b64_pkg;

   localparam int GROUPS_PER_LINE = 19;
   localparam int LINE_CNT_W      = 5;
   localparam int MAX_BURST       = 6;
   localparam int BURST_CNT_W     = 3;
   localparam int BURST_IDX_W     = 3;

   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   typedef enum logic [1:0] {
      PHASE_EMPTY = 2'd0,
      PHASE_ONE   = 2'd1,
      PHASE_TWO   = 2'd2
   } phase_type;

   typedef logic [7:0] char_type;

   typedef struct packed {
      char_type [MAX_BURST-1:0]  chars;
      logic [BURST_CNT_W-1:0]    count;
   } burst_type;

   // standard alphabet: A-Z a-z 0-9 + /
   function automatic char_type sym_char(input logic [5:0] v);
      char_type c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/b64_if.sv @@
// valid/ready channel interfaces for raw bytes in and characters out
`default_nettype none

interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;
   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_run;
   modport source (output valid, output out_char, output end_of_run, input ready);
   modport sink   (input valid, input out_char, input end_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/b64_core.sv @@
// group state and character formation for one accepted byte
`default_nettype none

module b64_core
   import b64_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       is_final,
   output burst_type       burst
);

   logic [15:0]           pending_ff, pending_in;
   phase_type             phase_ff, phase_in;
   logic [LINE_CNT_W-1:0] line_ff, line_in;

   logic [7:0]            b0, b1;
   logic [LINE_CNT_W-1:0] line_next;
   logic                  line_break;

   assign b0 = pending_ff[15:8];
   assign b1 = pending_ff[7:0];
   assign line_next  = line_ff + LINE_CNT_W'(1);
   assign line_break = (line_next >= LINE_CNT_W'(GROUPS_PER_LINE)) ||
                       (line_next == '0);

   always_comb begin
      pending_in  = pending_ff;
      phase_in    = phase_ff;
      line_in     = line_ff;
      burst.chars = '0;
      burst.count = '0;
      case (phase_ff)
         PHASE_EMPTY: begin
            if (is_final) begin
               burst.chars[0] = sym_char(data_byte[7:2]);
               burst.chars[1] = sym_char({data_byte[1:0], 4'b0000});
               burst.chars[2] = CHAR_PAD;
               burst.chars[3] = CHAR_PAD;
               burst.count    = BURST_CNT_W'(4);
            end else begin
               pending_in = {data_byte, 8'h00};
               phase_in   = PHASE_ONE;
            end
         end
         PHASE_ONE: begin
            if (is_final) begin
               burst.chars[0] = sym_char(b0[7:2]);
               burst.chars[1] = sym_char({b0[1:0], data_byte[7:4]});
               burst.chars[2] = sym_char({data_byte[3:0], 2'b00});
               burst.chars[3] = CHAR_PAD;
               burst.count    = BURST_CNT_W'(4);
            end else begin
               pending_in = {b0, data_byte};
               phase_in   = PHASE_TWO;
            end
         end
         PHASE_TWO: begin
            burst.chars[0] = sym_char(b0[7:2]);
            burst.chars[1] = sym_char({b0[1:0], b1[7:4]});
            burst.chars[2] = sym_char({b1[3:0], data_byte[7:6]});
            burst.chars[3] = sym_char(data_byte[5:0]);
            if (line_break) begin
               burst.chars[4] = CHAR_CR;
               burst.chars[5] = CHAR_LF;
               burst.count    = BURST_CNT_W'(6);
               line_in        = '0;
            end else begin
               burst.count    = BURST_CNT_W'(4);
               line_in        = line_next;
            end
            pending_in = '0;
            phase_in   = PHASE_EMPTY;
         end
         default: begin
            pending_in = '0;
            phase_in   = PHASE_EMPTY;
            line_in    = '0;
         end
      endcase
      // end of message clears everything, line count included
      if (is_final) begin
         pending_in = '0;
         phase_in   = PHASE_EMPTY;
         line_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         phase_ff   <= PHASE_EMPTY;
         line_ff    <= '0;
      end else if (fire) begin
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
         line_ff    <= line_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/b64_serializer.sv @@
// holds one burst of characters and sends it out one beat per cycle while rsp_bus.ready is high
`default_nettype none

module b64_serializer
   import b64_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire burst_type burst,
   output logic           can_take,
   b64_rsp_if.source      rsp_bus
);

   char_type [MAX_BURST-1:0] chars_ff;
   logic [BURST_CNT_W-1:0]   count_ff;
   logic [BURST_IDX_W-1:0]   idx_ff;
   logic                     busy_ff;
   logic                     last;

   assign last     = (BURST_CNT_W'(idx_ff) + BURST_CNT_W'(1)) == count_ff;
   assign can_take = !busy_ff || (last && rsp_bus.ready);

   assign rsp_bus.valid      = busy_ff;
   assign rsp_bus.out_char   = chars_ff[idx_ff];
   assign rsp_bus.end_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_bus.ready) begin
         if (last) begin
            busy_ff <= 1'b0;
         end
         idx_ff <= idx_ff + BURST_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff <= burst.chars;
         count_ff <= burst.count;
      end
   end

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
// top level of the base64 stream encoder with 76-character lines
//
// usage:
//   req_bus carries one raw byte per beat (data_byte) and is_final on the
//   last byte of a message. rsp_bus carries one ASCII character per beat
//   (out_char); end_of_run marks the last character caused by one input byte.
//   every third byte yields four alphabet characters, plus CR LF once
//   GROUPS_PER_LINE groups sit on the line; a final byte that leaves one or
//   two bytes yields a tail padded with "==" or "=". other bytes yield nothing.
// latency: the first character of a burst shows on rsp_bus the cycle after
//   its byte is accepted.
// throughput: one character per cycle while rsp_bus.ready is high, set by
//   the single output beat; a byte that causes 4 or 6 characters holds off
//   later bytes until they drain, and a byte that only joins the group is
//   taken with no output; a new byte is taken alongside a burst's last character.
// reset: synchronous, active high; clears the group phase, held bytes, line
//   count and any burst in flight.
// stall: while rsp_bus.ready is low the current character holds and req_bus
//   stays not ready until the burst's last beat is taken.
`default_nettype none

module base64_stream_encoder
   import b64_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   b64_req_if.sink   req_bus,
   b64_rsp_if.source rsp_bus
);

   burst_type burst;
   logic      can_take;
   logic      fire;

   // a byte is taken whenever the output buffer is free or frees this cycle
   assign req_bus.ready = can_take;
   assign fire          = req_bus.valid && can_take;

   // group state and the characters this byte causes
   b64_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_bus.data_byte),
      .is_final  (req_bus.is_final),
      .burst     (burst)
   );

   // bytes that cause no characters skip the buffer
   b64_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .load     (fire && (burst.count != '0)),
      .burst    (burst),
      .can_take (can_take),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/b64_checker.sv @@
// port-level checks on the encoder, bound to the top level
`default_nettype none

module b64_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char,
   input wire logic       rsp_end
);

   // reset empties the output buffer
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // a burst runs without gaps until its last beat
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end |=> rsp_valid)
      else $error("gap inside a burst");

   // a new byte is only taken once the burst in flight is finishing
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || (rsp_ready && rsp_end))
      else $error("byte accepted over a pending burst");

   // a stalled character holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_end))
      else $error("stalled character changed");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_char  (rsp_bus.out_char),
   .rsp_end   (rsp_bus.end_of_run)
);

`default_nettype wire
